// ----- rtl/core/sp_pkg.sv -----
// ----------------------------------------------------------------------------
// Stereographic projection package
// Shared widths, codes and fixed-point constants of the projection pipeline.
// ----------------------------------------------------------------------------
package sp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Magnitudes of signed inputs fit DATA_WIDTH unsigned bits.
  localparam int SQ_W   = 2 * DATA_WIDTH;
  localparam int ROOT_W = DATA_WIDTH;

  // Backward sum p = x^2 + y^2 plus the constant 4.0 in raw units.
  localparam int PW = (SQ_W > 2 * FRAC_BITS + 3) ? SQ_W : 2 * FRAC_BITS + 3;

  localparam int NUM_FWD_W = SQ_W + 1;
  localparam int NUM_BX_W  = DATA_WIDTH + 2 * FRAC_BITS + 2;
  localparam int NUM_BZ_W  = PW + FRAC_BITS;
  localparam int NUM_A_W   = (NUM_FWD_W > NUM_BX_W) ? NUM_FWD_W : NUM_BX_W;
  localparam int NUM_W     = (NUM_A_W > NUM_BZ_W) ? NUM_A_W : NUM_BZ_W;
  localparam int DEN_W     = PW;
  localparam int QUO_W     = DATA_WIDTH;
  localparam int REM_W     = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_BWD = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [DATA_WIDTH-1:0]        mag_t;

endpackage

// ----- rtl/core/sp_if.sv -----
// ----------------------------------------------------------------------------
// Stereographic projection channels
// Valid/ready channels for input vectors and projected results.
// ----------------------------------------------------------------------------
interface sp_vec_if import sp_pkg::*;;
  logic  valid;
  logic  ready;
  logic  mode;
  word_t vec_x;
  word_t vec_y;
  word_t vec_z;

  modport source (output valid, mode, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, mode, vec_x, vec_y, vec_z, output ready);
endinterface

interface sp_res_if import sp_pkg::*;;
  logic  valid;
  logic  ready;
  word_t res_x;
  word_t res_y;
  word_t res_z;
  logic  ok;
  logic  overflow;

  modport source (output valid, res_x, res_y, res_z, ok, overflow, input ready);
  modport sink   (input valid, res_x, res_y, res_z, ok, overflow, output ready);
endinterface

// ----- rtl/core/sp_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per register stage; floor of the square root of rad.
// ----------------------------------------------------------------------------
module sp_sqrt import sp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   rad,
  output logic [ROOT_W-1:0] root
);

  logic [SQ_W-1:0] num [0:ROOT_W];
  logic [SQ_W-1:0] acc [0:ROOT_W];

  assign num[0] = rad;
  assign acc[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] trial;
    logic            take;

    assign trial = acc[k] + BIT;
    assign take  = num[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1] <= take ? num[k] - trial : num[k];
        acc[k+1] <= take ? (acc[k] >> 1) + BIT : (acc[k] >> 1);
      end
    end
  end

  assign root = acc[ROOT_W][ROOT_W-1:0];

endmodule

// ----- rtl/core/sp_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Quotient truncated to QUO_W bits, one bit per stage; big flags a quotient
// that does not fit.
// ----------------------------------------------------------------------------
module sp_div import sp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             big
);

  logic [REM_W-1:0] rem [0:QUO_W-1];
  logic [DEN_W-1:0] dv  [0:QUO_W-1];
  logic [QUO_W-1:0] qv  [0:QUO_W];
  logic             bg  [0:QUO_W];

  // The quotient fits QUO_W bits exactly when num < den * 2^QUO_W.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= REM_W'(num);
      dv[0]  <= den;
      qv[0]  <= '0;
      bg[0]  <= (REM_W'(num) >> QUO_W) >= REM_W'(den);
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic [REM_W-1:0] shd;
    logic             take;

    assign shd  = REM_W'(dv[k]) << SH;
    assign take = rem[k] >= shd;

    always_ff @(posedge clk) begin
      if (en) begin
        qv[k+1] <= qv[k] | (QUO_W'(take) << SH);
        bg[k+1] <= bg[k];
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= take ? rem[k] - shd : rem[k];
          dv[k+1]  <= dv[k];
        end
      end
    end
  end

  assign quo = qv[QUO_W];
  assign big = bg[QUO_W];

endmodule

// ----- rtl/core/stereographic_projection.sv -----
// ----------------------------------------------------------------------------
// Stereographic projection
// Forward projection and backward unprojection of signed fixed-point vectors.
// ----------------------------------------------------------------------------
// The block takes one vector transfer per clock cycle while it is not held
// and returns one result transfer for each, in order. The square root
// resolves one root bit per stage, and the three dividers resolve one
// quotient bit per stage after a range check. The whole pipeline advances
// together: when the result register holds a transfer that is not taken,
// every stage holds, and vec.ready drops in the same cycle. Forward mode
// gives 2xd/(d-z), 2yd/(d-z) and -d with d the floored root of x^2+y^2+z^2;
// at the pole or for the zero vector it gives zeros with ok clear. Backward
// mode gives (x, y, q-1)/(q+1) with q = (x^2+y^2)/4 and ok set. Quotients
// truncate toward zero and every component that leaves the signed range
// saturates and raises overflow.
// ----------------------------------------------------------------------------
module stereographic_projection import sp_pkg::*; (
  input logic          clk,
  input logic          rst,
  sp_vec_if.sink       vec,
  sp_res_if.source     res
);

  localparam int NST = 2 * DATA_WIDTH + 6;
  localparam logic [PW-1:0] BWD_FOUR = PW'(1) << (2 * FRAC_BITS + 2);

  typedef struct packed {
    logic mode;
    logic nx;
    logic ny;
    logic nz;
    mag_t mx;
    mag_t my;
    mag_t mz;
  } front_t;

  typedef struct packed {
    front_t          f;
    logic [SQ_W-1:0] p;
  } mid_t;

  typedef struct packed {
    logic mode;
    logic nx;
    logic ny;
    logic zneg;
    logic pole;
    mag_t d;
  } back_t;

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  // Signed saturation of a magnitude and its sign.
  function automatic sat_t sat_pack(input logic neg, input logic big,
                                    input mag_t q);
    mag_t lim;
    sat_t r;
    lim   = neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    r.ovf = big || (q > lim);
    r.val = r.ovf ? (neg ? word_t'(-lim) : word_t'(lim))
                  : (neg ? word_t'(-q) : word_t'(q));
    return r;
  endfunction

  logic en;
  logic [NST-1:0] vld;

  // The pipeline moves whenever the result register is empty or being read.
  assign en        = !vld[NST-1] || res.ready;
  assign vec.ready = en;
  assign res.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], vec.valid};
    end
  end

  // Input register: split into sign and magnitude.
  front_t f0;
  always_ff @(posedge clk) begin
    if (en) begin
      f0.mode <= vec.mode;
      f0.nx   <= vec.vec_x[DATA_WIDTH-1];
      f0.ny   <= vec.vec_y[DATA_WIDTH-1];
      f0.nz   <= vec.vec_z[DATA_WIDTH-1];
      f0.mx   <= vec.vec_x[DATA_WIDTH-1] ? mag_t'(-vec.vec_x) : mag_t'(vec.vec_x);
      f0.my   <= vec.vec_y[DATA_WIDTH-1] ? mag_t'(-vec.vec_y) : mag_t'(vec.vec_y);
      f0.mz   <= vec.vec_z[DATA_WIDTH-1] ? mag_t'(-vec.vec_z) : mag_t'(vec.vec_z);
    end
  end

  // Squares.
  front_t f1;
  logic [SQ_W-1:0] sqx, sqy, sqz;
  always_ff @(posedge clk) begin
    if (en) begin
      f1  <= f0;
      sqx <= SQ_W'(f0.mx) * SQ_W'(f0.mx);
      sqy <= SQ_W'(f0.my) * SQ_W'(f0.my);
      sqz <= SQ_W'(f0.mz) * SQ_W'(f0.mz);
    end
  end

  // Sums: the full sum feeds the root, the planar one is kept for backward.
  mid_t m2;
  logic [SQ_W-1:0] s2;
  always_ff @(posedge clk) begin
    if (en) begin
      m2.f <= f1;
      m2.p <= sqx + sqy;
      s2   <= sqx + sqy + sqz;
    end
  end

  logic [ROOT_W-1:0] root;
  mid_t ms [0:ROOT_W-1];

  sp_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s2),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ms[0] <= m2;
      for (int k = 1; k < ROOT_W; k++) begin
        ms[k] <= ms[k-1];
      end
    end
  end

  // Numerators and denominators for both modes.
  mid_t            mr;
  logic [ROOT_W:0] fden;
  logic [PW-1:0]   bden, diff;
  logic            zneg;
  logic [SQ_W-1:0] prod_x, prod_y;

  assign mr     = ms[ROOT_W-1];
  assign fden   = mr.f.nz ? {1'b0, root} + {1'b0, mr.f.mz} : {1'b0, root} - {1'b0, mr.f.mz};
  assign bden   = PW'(mr.p) + BWD_FOUR;
  assign zneg   = PW'(mr.p) < BWD_FOUR;
  assign diff   = zneg ? BWD_FOUR - PW'(mr.p) : PW'(mr.p) - BWD_FOUR;
  assign prod_x = SQ_W'(mr.f.mx) * SQ_W'(root);
  assign prod_y = SQ_W'(mr.f.my) * SQ_W'(root);

  logic [NUM_W-1:0] num_x, num_y, num_z;
  logic [DEN_W-1:0] den;
  back_t            ba;

  always_ff @(posedge clk) begin
    if (en) begin
      if (mr.f.mode == MODE_FWD) begin
        num_x <= NUM_W'({prod_x, 1'b0});
        num_y <= NUM_W'({prod_y, 1'b0});
        num_z <= '0;
        den   <= DEN_W'(fden);
      end else begin
        num_x <= NUM_W'(mr.f.mx) << (2 * FRAC_BITS + 2);
        num_y <= NUM_W'(mr.f.my) << (2 * FRAC_BITS + 2);
        num_z <= NUM_W'(diff) << FRAC_BITS;
        den   <= DEN_W'(bden);
      end
      ba.mode <= mr.f.mode;
      ba.nx   <= mr.f.nx;
      ba.ny   <= mr.f.ny;
      ba.zneg <= zneg;
      ba.pole <= fden == '0;
      ba.d    <= root;
    end
  end

  logic [QUO_W-1:0] qx, qy, qz;
  logic             bx, by, bz;
  back_t            bs [0:QUO_W];

  sp_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(den), .quo(qx), .big(bx));
  sp_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(den), .quo(qy), .big(by));
  sp_div u_div_z (.clk(clk), .en(en), .num(num_z), .den(den), .quo(qz), .big(bz));

  always_ff @(posedge clk) begin
    if (en) begin
      bs[0] <= ba;
      for (int k = 1; k <= QUO_W; k++) begin
        bs[k] <= bs[k-1];
      end
    end
  end

  // Saturation and the result register.
  back_t bo;
  sat_t  sx, sy, sz;

  assign bo = bs[QUO_W];
  assign sx = sat_pack(bo.nx, bx, qx);
  assign sy = sat_pack(bo.ny, by, qy);
  assign sz = (bo.mode == MODE_FWD) ? sat_pack(1'b1, 1'b0, bo.d)
                                    : sat_pack(bo.zneg, bz, qz);

  always_ff @(posedge clk) begin
    if (en) begin
      if (bo.mode == MODE_FWD && bo.pole) begin
        res.res_x    <= '0;
        res.res_y    <= '0;
        res.res_z    <= '0;
        res.ok       <= 1'b0;
        res.overflow <= 1'b0;
      end else begin
        res.res_x    <= sx.val;
        res.res_y    <= sy.val;
        res.res_z    <= sz.val;
        res.ok       <= 1'b1;
        res.overflow <= sx.ovf || sy.ovf || sz.ovf;
      end
    end
  end

endmodule

// ----- rtl/core/sp_checker.sv -----
// ----------------------------------------------------------------------------
// Stereographic projection checker
// Port-level assertions on flow control and result flags.
// ----------------------------------------------------------------------------
module sp_checker import sp_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  vec_ready,
  input logic  res_valid,
  input logic  res_ready,
  input word_t res_x,
  input word_t res_y,
  input word_t res_z,
  input logic  ok,
  input logic  overflow
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a held result.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !vec_ready |-> (res_valid && !res_ready))
    else $error("input stalled without a held result");

  // A failed projection carries zeros and no overflow.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !ok) |-> (res_x == '0 && res_y == '0 && res_z == '0 && !overflow))
    else $error("failed projection with nonzero result");

  // A held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_x) && $stable(res_y)
                                   && $stable(res_z) && $stable(ok)
                                   && $stable(overflow)))
    else $error("held result changed");

endmodule

bind stereographic_projection sp_checker u_sp_checker (
  .clk       (clk),
  .rst       (rst),
  .vec_ready (vec.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_x     (res.res_x),
  .res_y     (res.res_y),
  .res_z     (res.res_z),
  .ok        (res.ok),
  .overflow  (res.overflow)
);

// ----- verif/stereographic_projection_test.sv -----
// ----------------------------------------------------------------------------
// Stereographic projection testbench
// Drives forward and backward vectors through the projection pipeline with
// random idling on both channels and checks every result transfer against an
// exact integer predictor of the projection arithmetic or a typed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereographic_projection_test;
  import sp_pkg::*;

  localparam int LATENCY = 2 * DATA_WIDTH + 6;

  typedef struct packed {
    logic  mode;
    word_t x;
    word_t y;
    word_t z;
  } vec_item_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  ok;
    logic  overflow;
  } proj_result_t;

  // One row of the directed table: a vector and, where it is obvious, the
  // result that it must give.
  typedef struct packed {
    vec_item_t    item;
    logic         typed;
    proj_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   failed = 1'b0;
  bit   no_idle = 1'b0;

  proj_result_t pending_results[$];

  sp_vec_if vec ();
  sp_res_if res ();

  stereographic_projection u_top (
    .clk (clk),
    .rst (rst),
    .vec (vec.sink),
    .res (res.source)
  );

  always #6 clk = ~clk;

  // Clamps a sign and a magnitude to the signed word range.
  function automatic word_t clamp_word(input bit neg, input logic [191:0] mag,
                                       inout logic ovf);
    logic [191:0] lim;
    logic [191:0] m;
    begin
      lim = neg ? (192'd1 << (DATA_WIDTH - 1)) : ((192'd1 << (DATA_WIDTH - 1)) - 1);
      m = mag;
      if (mag > lim) begin
        ovf = 1'b1;
        m = lim;
      end
      clamp_word = neg ? word_t'(-m) : word_t'(m);
    end
  endfunction

  // Floored integer square root of a sum of squares.
  function automatic logic [63:0] floor_root(input logic [191:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    begin
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (192'(c) * 192'(c) <= s) r = c;
      end
      floor_root = r;
    end
  endfunction

  function automatic proj_result_t project(input vec_item_t it);
    proj_result_t r;
    logic [191:0] mx, my, mz, s, dd, den, p, c, diff;
    logic [63:0]  d;
    logic         ovf;
    bit           nx, ny, nz, zneg;
    begin
      nx = it.x[DATA_WIDTH-1];
      ny = it.y[DATA_WIDTH-1];
      nz = it.z[DATA_WIDTH-1];
      mx = 192'(mag_t'(nx ? -it.x : it.x));
      my = 192'(mag_t'(ny ? -it.y : it.y));
      mz = 192'(mag_t'(nz ? -it.z : it.z));
      ovf = 1'b0;
      r = '0;
      if (it.mode == MODE_FWD) begin
        s = mx * mx + my * my + mz * mz;
        d = floor_root(s);
        dd = 192'(d);
        // The denominator d - z is exact; z is positive only in the minus case.
        den = nz ? dd + mz : dd - mz;
        if (den == 0) return r;  // pole or zero vector
        r.x = clamp_word(nx, ((mx * dd) << 1) / den, ovf);
        r.y = clamp_word(ny, ((my * dd) << 1) / den, ovf);
        r.z = clamp_word(1'b1, dd, ovf);
      end else begin
        p = mx * mx + my * my;
        c = 192'd1 << (2 * FRAC_BITS + 2);
        den = p + c;
        zneg = p < c;
        diff = zneg ? c - p : p - c;
        r.x = clamp_word(nx, (mx << (2 * FRAC_BITS + 2)) / den, ovf);
        r.y = clamp_word(ny, (my << (2 * FRAC_BITS + 2)) / den, ovf);
        r.z = clamp_word(zneg, (diff << FRAC_BITS) / den, ovf);
      end
      r.ok = 1'b1;
      r.overflow = ovf;
      project = r;
    end
  endfunction

  function automatic word_t random_word();
    word_t w;
    begin
      w = word_t'($urandom);
      case ($urandom_range(0, 5))
        0: w = w >>> $urandom_range(0, 31);  // any magnitude
        1: w = word_t'($signed(w[20:0]));      // small magnitudes, up to 16.0
        2: w = word_t'($signed(w[17:0]));
        default: ;
      endcase
      random_word = w;
    end
  endfunction

  // Stalls are skipped during the quiet stretch.
  function automatic bit idle_now();
    idle_now = !no_idle && ($urandom_range(0, 99) < 27);
  endfunction

  task automatic send_vector(input vec_item_t it);
    begin
      while (idle_now()) begin
        vec.valid <= 1'b0;
        @(posedge clk);
      end
      vec.valid <= 1'b1;
      vec.mode  <= it.mode;
      vec.vec_x <= it.x;
      vec.vec_y <= it.y;
      vec.vec_z <= it.z;
      @(posedge clk);
      while (!vec.ready) @(posedge clk);
      pending_results.push_back(project(it));
    end
  endtask

  // Sink side: random back-pressure, and a check of each result transfer.
  always @(posedge clk) begin
    proj_result_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer");
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (res.res_x !== want.x) begin
            $error("res_x expected %0d actual %0d", want.x, res.res_x);
            failed = 1'b1;
          end
          if (res.res_y !== want.y) begin
            $error("res_y expected %0d actual %0d", want.y, res.res_y);
            failed = 1'b1;
          end
          if (res.res_z !== want.z) begin
            $error("res_z expected %0d actual %0d", want.z, res.res_z);
            failed = 1'b1;
          end
          if (res.ok !== want.ok) begin
            $error("ok expected %0b actual %0b", want.ok, res.ok);
            failed = 1'b1;
          end
          if (res.overflow !== want.overflow) begin
            $error("overflow expected %0b actual %0b", want.overflow, res.overflow);
            failed = 1'b1;
          end
        end
      end
      res.ready <= !idle_now();
    end
  end

  localparam word_t ONE  = word_t'(1 << FRAC_BITS);
  localparam word_t WMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Directed vectors. Rows with a typed result are the pole, the zero vector
  // and the backward origin; the predictor covers the rest.
  stim_row_t directed_rows[] = '{
    '{'{MODE_FWD, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
    '{'{MODE_FWD, 0, 0, ONE}, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
    '{'{MODE_FWD, 0, 0, WMAX}, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
    '{'{MODE_FWD, 1, 0, ONE}, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
    '{'{MODE_BWD, 0, 0, WMAX}, 1'b1, '{0, 0, -ONE, 1'b1, 1'b0}},
    '{'{MODE_FWD, 0, 0, -ONE}, 1'b0, '0},
    '{'{MODE_FWD, ONE, 0, 0}, 1'b0, '0},
    '{'{MODE_FWD, 0, -ONE, 0}, 1'b0, '0},
    '{'{MODE_FWD, WMAX, WMAX, WMAX}, 1'b0, '0},
    '{'{MODE_FWD, WMIN, WMIN, WMIN}, 1'b0, '0},
    '{'{MODE_FWD, WMIN, 0, WMAX}, 1'b0, '0},
    '{'{MODE_FWD, 1, 1, 1}, 1'b0, '0},
    '{'{MODE_FWD, -1, -1, -1}, 1'b0, '0},
    '{'{MODE_FWD, WMAX, 0, WMIN}, 1'b0, '0},
    '{'{MODE_BWD, ONE, ONE, 0}, 1'b0, '0},
    '{'{MODE_BWD, 2 * ONE, 0, 0}, 1'b0, '0},
    '{'{MODE_BWD, WMAX, WMAX, 0}, 1'b0, '0},
    '{'{MODE_BWD, WMIN, WMIN, WMIN}, 1'b0, '0},
    '{'{MODE_BWD, -ONE, ONE, -1}, 1'b0, '0},
    '{'{MODE_BWD, 1, -1, 0}, 1'b0, '0}
  };

  initial begin
    vec_item_t it;
    vec.valid <= 1'b0;
    vec.mode  <= MODE_FWD;
    vec.vec_x <= '0;
    vec.vec_y <= '0;
    vec.vec_z <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_vector(directed_rows[i].item);
      // A typed expectation replaces the predicted one at the tail.
      if (directed_rows[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(directed_rows[i].want);
      end
    end

    for (int n = 0; n < 1800; n++) begin
      no_idle = (n >= 600 && n < 900);
      it.mode = 1'($urandom_range(0, 1));
      it.x = random_word();
      it.y = random_word();
      it.z = random_word();
      // Now and then put the vector on the pole axis.
      if ($urandom_range(0, 19) == 0) begin
        it.mode = MODE_FWD;
        it.x = 0;
        it.y = 0;
        it.z = word_t'($urandom_range(0, 1 << 20));
      end
      send_vector(it);
    end
    vec.valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("stereographic_projection_test passed");
    end else begin
      $display("stereographic_projection_test failed");
    end
    $finish;
  end

  // Watchdog sized for full stalls on both sides and the pipeline latency.
  initial begin
    #5ms;
    $display("stereographic_projection_test failed");
    $finish;
  end

endmodule
